/* design/voxel_map_nearest_neighbour_macros.svh */
// assertion macros used by the voxel map datapath
`ifndef VOXEL_MAP_NEAREST_NEIGHBOUR_MACROS_SVH
`define VOXEL_MAP_NEAREST_NEIGHBOUR_MACROS_SVH

// condition that holds at every clock edge out of reset
`define VMNN_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that implies another in the next cycle
`define VMNN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/vmnn_pkg.sv */
// shared constants, codes and types of the voxel map nearest neighbour block
package vmnn_pkg;

    localparam int VOXEL_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(VOXEL_SLOTS);
    localparam int POINTS_CAP  = 8;
    localparam int PIDX_W      = $clog2(POINTS_CAP);
    localparam int CNT_W       = $clog2(POINTS_CAP + 1);
    localparam int COORD_W     = 24;
    localparam int KEY_W       = 20;
    localparam int KEY_SHIFT   = 20;
    localparam int RECIP_W     = 16;
    localparam int MAXP_W      = 4;
    localparam int DIST_W      = 50;
    localparam int CFG_W       = 50;
    localparam int CFG_IDX_W   = 2;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 3;
    localparam int NCODE_W     = 5;
    localparam int PT_ADDR_W   = SLOT_W + PIDX_W;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXD  = 2'd2;

    localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd4096;
    localparam logic [MAXP_W-1:0]  MAXP_RESET  = 4'd8;
    localparam logic [DIST_W-1:0]  MAXD_RESET  = 50'd65536;

    localparam logic [STAT_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EVICTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NEW_VOXEL = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STAT_W-1:0] ST_MATCH     = 3'd6;
    localparam logic [STAT_W-1:0] ST_NO_MATCH  = 3'd7;

    typedef logic [2:0][KEY_W-1:0]   key_t;
    typedef logic [2:0][COORD_W-1:0] pt_t;

    typedef struct packed {
        key_t              key;
        logic [CNT_W-1:0]  cnt;
        logic [PIDX_W-1:0] head;
    } slot_ent_t;

    localparam int SLOT_DATA_W = $bits(slot_ent_t);
    localparam int PT_W        = $bits(pt_t);

    typedef struct packed {
        logic clr;
        logic cap;
        logic mul;
        logic key;
        logic scan_init;
        logic scan;
        logic q_issue;
        logic ins;
        logic r_cmp;
        logic s_rd;
        logic s_wr;
        logic r_done;
        logic nf;
        logic fin;
        logic fin_query;
    } cmd_t;

    typedef struct packed {
        logic             clr_last;
        logic [REQ_W-1:0] req;
        logic             scan_hit;
        logic             scan_done;
        logic             q_done;
        logic             r_eq;
        logic             last_idx;
        logic             out_free;
    } sts_t;

endpackage

/* design/vmnn_ram.sv */
// generic simple dual port ram with registered read
module vmnn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/vmnn_ctrl.sv */
// controller state machine sequencing clear, scan, insert, remove and query
module vmnn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  vmnn_pkg::sts_t sts,
    output vmnn_pkg::cmd_t cmd
);
    import vmnn_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_MUL   = 12'b0000_0000_0100,
        S_KEY   = 12'b0000_0000_1000,
        S_SCAN  = 12'b0000_0001_0000,
        S_QPTS  = 12'b0000_0010_0000,
        S_INS   = 12'b0000_0100_0000,
        S_RRD   = 12'b0000_1000_0000,
        S_RCMP  = 12'b0001_0000_0000,
        S_SRD   = 12'b0010_0000_0000,
        S_SWR   = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_KEY;
            end
            S_KEY:
            begin
                cmd.key       = 1'b1;
                cmd.scan_init = 1'b1;
                if (sts.req inside {REQ_INSERT, REQ_QUERY, REQ_REMOVE})
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_hit)
                begin
                    case (sts.req)
                        REQ_QUERY:  state_next = S_QPTS;
                        REQ_REMOVE: state_next = S_RRD;
                        default:    state_next = S_INS;
                    endcase
                end
                else if (sts.scan_done)
                begin
                    case (sts.req)
                        REQ_INSERT: state_next = S_INS;
                        REQ_REMOVE:
                        begin
                            cmd.nf     = 1'b1;
                            state_next = S_FIN;
                        end
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_QPTS:
            begin
                cmd.q_issue = 1'b1;
                if (sts.q_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = S_FIN;
            end
            S_RRD:
            begin
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                cmd.r_cmp = 1'b1;
                if (sts.r_eq)
                begin
                    state_next = S_SRD;
                end
                else if (sts.last_idx)
                begin
                    cmd.nf     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RRD;
                end
            end
            S_SRD:
            begin
                if (sts.last_idx)
                begin
                    cmd.r_done = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.s_rd   = 1'b1;
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                cmd.s_wr   = 1'b1;
                state_next = S_SRD;
            end
            S_FIN:
            begin
                cmd.fin_query = (sts.req == REQ_QUERY);
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/vmnn_dp.sv */
// datapath: config registers, key math, slot and point memories, distance search
`include "voxel_map_nearest_neighbour_macros.svh"
module vmnn_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vmnn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vmnn_pkg::CFG_W-1:0]           cfg_data,
    input  logic [vmnn_pkg::REQ_W-1:0]           req_type,
    input  logic signed [vmnn_pkg::COORD_W-1:0]  point_x,
    input  logic signed [vmnn_pkg::COORD_W-1:0]  point_y,
    input  logic signed [vmnn_pkg::COORD_W-1:0]  point_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vmnn_pkg::STAT_W-1:0]          status,
    output logic signed [vmnn_pkg::COORD_W-1:0]  target_x,
    output logic signed [vmnn_pkg::COORD_W-1:0]  target_y,
    output logic signed [vmnn_pkg::COORD_W-1:0]  target_z,
    input  vmnn_pkg::cmd_t                       cmd,
    output vmnn_pkg::sts_t                       sts
);
    import vmnn_pkg::*;

    localparam int PROD_W = COORD_W + RECIP_W + 1;
    localparam int DF_W   = COORD_W + 1;
    localparam int DK_W   = KEY_W + 1;

    // config
    logic [RECIP_W-1:0] recip_reg;
    logic [MAXP_W-1:0]  maxp_reg;
    logic [DIST_W-1:0]  maxd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_reg <= RECIP_RESET;
            maxp_reg  <= MAXP_RESET;
            maxd_reg  <= MAXD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RECIP: recip_reg <= cfg_data[RECIP_W-1:0];
                CFG_MAXP:  maxp_reg  <= cfg_data[MAXP_W-1:0];
                CFG_MAXD:  maxd_reg  <= cfg_data[DIST_W-1:0];
                default:   ;
            endcase
        end
    end

    // request word and key
    logic [REQ_W-1:0]          req_reg;
    pt_t                       pt_reg;
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [PROD_W-1:0]  adj [3];
    key_t                      key_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            adj[a] = prod_reg[a] + $signed({{(PROD_W-KEY_SHIFT){1'b0}},
                                            {KEY_SHIFT{prod_reg[a][PROD_W-1]}}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            req_reg   <= req_type;
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
        end
        if (cmd.mul)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= $signed(pt_reg[a]) * $signed({1'b0, recip_reg});
            end
        end
        if (cmd.key)
        begin
            for (int a = 0; a < 3; a++)
            begin
                key_reg[a] <= adj[a][KEY_SHIFT +: KEY_W];
            end
        end
    end

    // memories
    logic                   swe;
    logic [SLOT_W-1:0]      swaddr;
    slot_ent_t              swent;
    logic [SLOT_DATA_W-1:0] srdata;
    logic                   pwe;
    logic [PT_ADDR_W-1:0]   pwaddr;
    pt_t                    pwdata;
    logic [PT_ADDR_W-1:0]   praddr;
    logic [PT_W-1:0]        prdata;
    logic [SLOT_W:0]        scan_reg;

    vmnn_ram #(
        .WIDTH (SLOT_DATA_W),
        .DEPTH (VOXEL_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (swe),
        .waddr (swaddr),
        .wdata (swent),
        .raddr (scan_reg[SLOT_W-1:0]),
        .rdata (srdata)
    );

    vmnn_ram #(
        .WIDTH (PT_W),
        .DEPTH (VOXEL_SLOTS * POINTS_CAP)
    ) u_point_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (pwaddr),
        .wdata (pwdata),
        .raddr (praddr),
        .rdata (prdata)
    );

    // slot scan
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    slot_ent_t         ent;
    logic              ent_valid;
    logic signed [DK_W-1:0] dk [3];
    logic [2:0]        axis_zero;
    logic [2:0]        axis_near;
    logic [1:0]        code [3];
    logic [NCODE_W-1:0] ncode;
    logic              scan_hit;

    always_comb
    begin
        ent       = slot_ent_t'(srdata);
        ent_valid = (ent.cnt != '0);
        for (int a = 0; a < 3; a++)
        begin
            dk[a] = $signed({ent.key[a][KEY_W-1], ent.key[a]})
                  - $signed({key_reg[a][KEY_W-1], key_reg[a]});
            axis_zero[a] = (dk[a] == '0);
            axis_near[a] = (dk[a] == '0) || (dk[a] == DK_W'(1)) || (dk[a] == '1);
            code[a]      = dk[a][1:0] + 2'd1;
        end
        ncode = NCODE_W'(code[0]) * NCODE_W'(9) + NCODE_W'(code[1]) * NCODE_W'(3)
              + NCODE_W'(code[2]);
        scan_hit = rd_vld_reg && ent_valid &&
                   ((req_reg == REQ_QUERY) ? (&axis_near) : (&axis_zero));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else if (cmd.clr)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        else if (cmd.scan_init)
        begin
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (scan_hit)
            begin
                scan_reg   <= {1'b0, rd_idx_reg} + 1'b1;
                rd_vld_reg <= 1'b0;
            end
            else if (!scan_reg[SLOT_W])
            begin
                rd_vld_reg <= 1'b1;
                rd_idx_reg <= scan_reg[SLOT_W-1:0];
                scan_reg   <= scan_reg + 1'b1;
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    // hit and free slot tracking
    logic              match_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [CNT_W-1:0]  cur_count_reg;
    logic [PIDX_W-1:0] cur_head_reg;
    logic [NCODE_W-1:0] cur_n_reg;
    logic [CNT_W-1:0]  pidx_reg;
    logic              r_eq;
    logic              v1_reg;
    logic              v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            cur_slot_reg   <= '0;
            cur_count_reg  <= '0;
            cur_head_reg   <= '0;
            cur_n_reg      <= '0;
            pidx_reg       <= '0;
        end
        else
        begin
            if (cmd.scan_init)
            begin
                match_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan && rd_vld_reg)
            begin
                if (!ent_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= rd_idx_reg;
                end
                if (scan_hit)
                begin
                    match_reg     <= 1'b1;
                    cur_slot_reg  <= rd_idx_reg;
                    cur_count_reg <= ent.cnt;
                    cur_head_reg  <= ent.head;
                    cur_n_reg     <= ncode;
                end
            end
            if (cmd.scan && scan_hit)
            begin
                pidx_reg <= '0;
            end
            else if ((cmd.q_issue && (pidx_reg != cur_count_reg)) ||
                     (cmd.r_cmp && !r_eq) || cmd.s_wr)
            begin
                pidx_reg <= pidx_reg + 1'b1;
            end
        end
    end

    // point addressing
    logic [CNT_W-1:0]  pidx_sel;
    logic [PIDX_W-1:0] phys_rd;
    logic [CNT_W:0]    pidx_inc;

    assign pidx_sel = cmd.s_rd ? (pidx_reg + 1'b1) : pidx_reg;
    assign phys_rd  = cur_head_reg + pidx_sel[PIDX_W-1:0];
    assign praddr   = {cur_slot_reg, phys_rd};
    assign pidx_inc = {1'b0, pidx_reg} + 1'b1;
    assign r_eq     = (pt_t'(prdata) == pt_reg);

    // insert bookkeeping
    logic [CNT_W-1:0]  cap_w;
    logic              evict;
    logic [PIDX_W-1:0] ins_head;
    logic [CNT_W-1:0]  ins_cnt;

    always_comb
    begin
        if (maxp_reg == '0)
        begin
            cap_w = CNT_W'(1);
        end
        else if (maxp_reg > MAXP_W'(POINTS_CAP))
        begin
            cap_w = CNT_W'(POINTS_CAP);
        end
        else
        begin
            cap_w = CNT_W'(maxp_reg);
        end
        evict    = (cur_count_reg >= cap_w);
        ins_head = evict ? (cur_head_reg + 1'b1) : cur_head_reg;
        ins_cnt  = evict ? (cur_count_reg - 1'b1) : cur_count_reg;
    end

    always_comb
    begin
        swe       = 1'b0;
        swaddr    = cur_slot_reg;
        swent     = '0;
        swent.key = key_reg;
        pwe       = 1'b0;
        pwaddr    = {cur_slot_reg, cur_head_reg + pidx_reg[PIDX_W-1:0]};
        pwdata    = pt_reg;
        if (cmd.clr)
        begin
            swe    = 1'b1;
            swaddr = scan_reg[SLOT_W-1:0];
            swent  = '0;
        end
        else if (cmd.ins)
        begin
            if (match_reg)
            begin
                swe        = 1'b1;
                swent.cnt  = ins_cnt + 1'b1;
                swent.head = ins_head;
                pwe        = 1'b1;
                pwaddr     = {cur_slot_reg, ins_head + ins_cnt[PIDX_W-1:0]};
            end
            else if (free_found_reg)
            begin
                swe        = 1'b1;
                swaddr     = free_slot_reg;
                swent.cnt  = CNT_W'(1);
                swent.head = '0;
                pwe        = 1'b1;
                pwaddr     = {free_slot_reg, {PIDX_W{1'b0}}};
            end
        end
        else if (cmd.r_done)
        begin
            swe        = 1'b1;
            swent.cnt  = cur_count_reg - 1'b1;
            swent.head = cur_head_reg;
        end
        else if (cmd.s_wr)
        begin
            pwe    = 1'b1;
            pwdata = pt_t'(prdata);
        end
    end

    // distance pipeline
    pt_t                      qpt_reg;
    logic signed [DF_W-1:0]   df [3];
    logic signed [2*DF_W-1:0] sqf [3];
    logic [DIST_W-2:0]        sq_reg [3];
    logic [DIST_W-1:0]        d_sum;
    logic                     better;
    logic                     best_found_reg;
    logic [DIST_W-1:0]        best_d_reg;
    logic [NCODE_W-1:0]       best_n_reg;
    pt_t                      best_pt_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            df[a]  = $signed({prdata[a*COORD_W + COORD_W-1], prdata[a*COORD_W +: COORD_W]})
                   - $signed({pt_reg[a][COORD_W-1], pt_reg[a]});
            sqf[a] = df[a] * df[a];
        end
        d_sum  = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        better = !best_found_reg || (d_sum < best_d_reg) ||
                 ((d_sum == best_d_reg) && (cur_n_reg < best_n_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.q_issue && (pidx_reg != cur_count_reg);
            v2_reg <= v1_reg;
            if (cmd.scan_init)
            begin
                best_found_reg <= 1'b0;
            end
            else if (v2_reg && better)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            qpt_reg <= pt_t'(prdata);
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= sqf[a][DIST_W-2:0];
            end
        end
        if (v2_reg && better)
        begin
            best_d_reg  <= d_sum;
            best_n_reg  <= cur_n_reg;
            best_pt_reg <= qpt_reg;
        end
    end

    // result word
    logic [STAT_W-1:0] status_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_out_reg;
    pt_t               tgt_reg;
    logic              is_match;

    assign is_match = best_found_reg && (best_d_reg < maxd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            status_reg <= ST_NO_MATCH;
        end
        else if (cmd.ins)
        begin
            if (match_reg)
            begin
                status_reg <= evict ? ST_EVICTED : ST_STORED;
            end
            else
            begin
                status_reg <= free_found_reg ? ST_NEW_VOXEL : ST_FULL;
            end
        end
        else if (cmd.r_done)
        begin
            status_reg <= ST_REMOVED;
        end
        else if (cmd.nf)
        begin
            status_reg <= ST_NOT_FOUND;
        end
        if (cmd.fin)
        begin
            if (cmd.fin_query && is_match)
            begin
                status_out_reg <= ST_MATCH;
                tgt_reg        <= best_pt_reg;
            end
            else
            begin
                status_out_reg <= cmd.fin_query ? ST_NO_MATCH : status_reg;
                tgt_reg        <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign target_x  = tgt_reg[0];
    assign target_y  = tgt_reg[1];
    assign target_z  = tgt_reg[2];

    // status to controller
    assign sts.clr_last  = (scan_reg[SLOT_W-1:0] == '1);
    assign sts.req       = req_reg;
    assign sts.scan_hit  = scan_hit;
    assign sts.scan_done = !rd_vld_reg && scan_reg[SLOT_W];
    assign sts.q_done    = (pidx_reg == cur_count_reg) && !v1_reg && !v2_reg;
    assign sts.r_eq      = r_eq;
    assign sts.last_idx  = (pidx_inc >= {1'b0, cur_count_reg});
    assign sts.out_free  = !out_valid_reg || !out_stall;

    `VMNN_ASSERT_HOLD(a_scan_bound, !scan_reg[SLOT_W] || (scan_reg[SLOT_W-1:0] == '0), "scan index ran past the slot table")
    `VMNN_ASSERT_HOLD(a_pts_nonempty, !v1_reg || (cur_count_reg != '0), "point read from an empty voxel")
    `VMNN_ASSERT_HOLD(a_pidx_bound, pidx_reg <= cur_count_reg, "point index beyond voxel count")
    `VMNN_ASSERT_NEXT(a_fin_out, cmd.fin, out_valid_reg, "result word not presented after finish")

endmodule

/* design/voxel_map_nearest_neighbour.sv */
// voxel map nearest neighbour top level: controller and datapath
// after reset a clearing pass empties the slot table; no word is taken meanwhile
// insert, remove, query scan the 1024-entry slot ram one entry per cycle unless a hit holds it
// remove compares the voxel's points in turn, then moves each later point down one place
// query reads every point of each neighbouring voxel found, at most 27 voxels of 8 points
// the next word is taken once the current result is registered
module voxel_map_nearest_neighbour (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vmnn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vmnn_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vmnn_pkg::REQ_W-1:0]           req_type,
    input  logic signed [vmnn_pkg::COORD_W-1:0]  point_x,
    input  logic signed [vmnn_pkg::COORD_W-1:0]  point_y,
    input  logic signed [vmnn_pkg::COORD_W-1:0]  point_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vmnn_pkg::STAT_W-1:0]          status,
    output logic signed [vmnn_pkg::COORD_W-1:0]  target_x,
    output logic signed [vmnn_pkg::COORD_W-1:0]  target_y,
    output logic signed [vmnn_pkg::COORD_W-1:0]  target_z
);
    import vmnn_pkg::*;

    cmd_t cmd;
    sts_t sts;

    vmnn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    vmnn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* bench/voxel_map_nearest_neighbour_tb.sv */
// testbench for the voxel map nearest neighbour block: random and directed requests against a predictor
`timescale 1ns / 100ps

module voxel_map_nearest_neighbour_tb;
    import vmnn_pkg::*;

    typedef struct {
        logic [REQ_W-1:0] rq;
        int               c[3];
    } request_t;

    typedef struct {
        logic [STAT_W-1:0]        st;
        logic signed [COORD_W-1:0] t[3];
    } answer_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = CFG_RECIP;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [REQ_W-1:0]           req_type = REQ_INSERT;
    logic signed [COORD_W-1:0]  point_x = '0;
    logic signed [COORD_W-1:0]  point_y = '0;
    logic signed [COORD_W-1:0]  point_z = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b1;
    logic [STAT_W-1:0]          status;
    logic signed [COORD_W-1:0]  target_x;
    logic signed [COORD_W-1:0]  target_y;
    logic signed [COORD_W-1:0]  target_z;

    request_t request_queue[$];
    answer_t  awaited_answers[$];
    int       stored_points[$][3];
    int       sent_cnt = 0;
    int       taken_cnt = 0;
    int       send_idle = 0;
    int       recv_idle = 0;
    int       errors = 0;
    int       quiet_cycles = 0;
    int       status_seen[8];

    // predictor copy of the map and registers
    int       m_recip;
    int       m_maxp;
    longint   m_maxd;
    bit       m_valid[VOXEL_SLOTS];
    int       m_key[VOXEL_SLOTS][3];
    int       m_cnt[VOXEL_SLOTS];
    int       m_pts[VOXEL_SLOTS][POINTS_CAP][3];

    voxel_map_nearest_neighbour i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int voxel_of(int c);
        longint p;
        p = longint'(c) * longint'(m_recip);
        return int'(p / 64'sd1048576);
    endfunction

    function automatic int find_voxel(int k0, int k1, int k2);
        for (int i = 0; i < VOXEL_SLOTS; i++)
        begin
            if (m_valid[i] && m_key[i][0] == k0 && m_key[i][1] == k1 && m_key[i][2] == k2)
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_oldest_at(int s, int idx);
        for (int j = idx; j < m_cnt[s] - 1; j++)
            m_pts[s][j] = m_pts[s][j+1];
        m_cnt[s]--;
    endfunction

    function automatic answer_t map_lookup(request_t r);
        answer_t a;
        int      k[3];
        int      s;
        int      cap;
        bit      found;
        longint  best_d;
        longint  d;
        longint  df;
        a.st = ST_NO_MATCH;
        a.t = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
            k[i] = voxel_of(r.c[i]);
        s = find_voxel(k[0], k[1], k[2]);
        if (r.rq == REQ_INSERT)
        begin
            if (s < 0)
            begin
                a.st = ST_FULL;
                for (int i = 0; i < VOXEL_SLOTS; i++)
                begin
                    if (!m_valid[i])
                    begin
                        m_valid[i] = 1'b1;
                        m_key[i] = k;
                        m_pts[i][0] = r.c;
                        m_cnt[i] = 1;
                        a.st = ST_NEW_VOXEL;
                        break;
                    end
                end
            end
            else
            begin
                cap = (m_maxp < 1) ? 1 : (m_maxp > POINTS_CAP) ? POINTS_CAP : m_maxp;
                a.st = ST_STORED;
                if (m_cnt[s] >= cap)
                begin
                    drop_oldest_at(s, 0);
                    a.st = ST_EVICTED;
                end
                if (m_cnt[s] < POINTS_CAP)
                begin
                    m_pts[s][m_cnt[s]] = r.c;
                    m_cnt[s]++;
                end
            end
        end
        else if (r.rq == REQ_REMOVE)
        begin
            a.st = ST_NOT_FOUND;
            if (s >= 0)
            begin
                for (int i = 0; i < m_cnt[s]; i++)
                begin
                    if (m_pts[s][i] == r.c)
                    begin
                        drop_oldest_at(s, i);
                        if (m_cnt[s] == 0)
                            m_valid[s] = 1'b0;
                        a.st = ST_REMOVED;
                        break;
                    end
                end
            end
        end
        else if (r.rq == REQ_QUERY)
        begin
            found = 1'b0;
            best_d = 0;
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++)
                    begin
                        s = find_voxel(k[0] + dx, k[1] + dy, k[2] + dz);
                        if (s < 0)
                            continue;
                        for (int i = 0; i < m_cnt[s]; i++)
                        begin
                            d = 0;
                            for (int ax = 0; ax < 3; ax++)
                            begin
                                df = longint'(m_pts[s][i][ax]) - longint'(r.c[ax]);
                                d += df * df;
                            end
                            if (!found || d < best_d)
                            begin
                                found = 1'b1;
                                best_d = d;
                                for (int ax = 0; ax < 3; ax++)
                                    a.t[ax] = COORD_W'(m_pts[s][i][ax]);
                            end
                        end
                    end
            if (found && best_d < m_maxd)
                a.st = ST_MATCH;
            else
                a.t = '{0, 0, 0};
        end
        return a;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle);
            if (taken_cnt == sent_cnt)
            begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    req_type <= request_queue[0].rq;
                    point_x  <= COORD_W'(request_queue[0].c[0]);
                    point_y  <= COORD_W'(request_queue[0].c[1]);
                    point_z  <= COORD_W'(request_queue[0].c[2]);
                    request_queue.delete(0);
                    in_valid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        request_t r;
        answer_t  e;
        answer_t  got;
        bit       moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r.rq = req_type;
                r.c = '{int'(point_x), int'(point_y), int'(point_z)};
                awaited_answers.insert(awaited_answers.size(), map_lookup(r));
                taken_cnt <= taken_cnt + 1;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got.st = status;
                got.t = '{target_x, target_y, target_z};
                if (awaited_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: expected none, actual status %0d", $time,
                             status);
                end
                else
                begin
                    e = awaited_answers[0];
                    awaited_answers.delete(0);
                    status_seen[e.st]++;
                    if (got.st !== e.st)
                    begin
                        errors++;
                        $display("%0t: status: expected %0d, actual %0d", $time, e.st, got.st);
                    end
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        if (got.t[ax] !== e.t[ax])
                        begin
                            errors++;
                            $display("%0t: target axis %0d: expected %0d, actual %0d", $time,
                                     ax, e.t[ax], got.t[ax]);
                        end
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RECIP)
            m_recip = int'(val[RECIP_W-1:0]);
        else if (idx == CFG_MAXP)
            m_maxp = int'(val[MAXP_W-1:0]);
        else if (idx == CFG_MAXD)
            m_maxd = longint'(val[DIST_W-1:0]);
    endtask

    task automatic drain();
        while (request_queue.size() != 0 || taken_cnt != sent_cnt || awaited_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_req(logic [REQ_W-1:0] rq, int x, int y, int z);
        request_t r;
        r.rq = rq;
        r.c = '{x, y, z};
        request_queue.insert(request_queue.size(), r);
    endtask

    function automatic int near_coord(int ctr, int vsz);
        int v;
        v = ctr + int'($urandom_range(0, 4 * vsz)) - 2 * vsz;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v;
    endfunction

    task automatic random_phase(int n);
        int ctr[3][3];
        int vsz;
        int c[3];
        int sel;
        int pick;
        logic signed [COORD_W-1:0] raw[3];
        vsz = 1048576 / m_recip;
        if (vsz > (1 << 21))
            vsz = 1 << 21;
        for (int i = 0; i < 3; i++)
            for (int ax = 0; ax < 3; ax++)
                ctr[i][ax] = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        for (int n_i = 0; n_i < n; n_i++)
        begin
            sel = $urandom_range(0, 99);
            pick = $urandom_range(0, 2);
            for (int ax = 0; ax < 3; ax++)
                c[ax] = near_coord(ctr[pick][ax], vsz);
            if (sel < 45)
            begin
                add_req(REQ_INSERT, c[0], c[1], c[2]);
                stored_points.insert(stored_points.size(), c);
            end
            else if (sel < 75)
            begin
                add_req(REQ_QUERY, c[0], c[1], c[2]);
            end
            else if (sel < 94)
            begin
                if (stored_points.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    pick = $urandom_range(0, stored_points.size() - 1);
                    c = stored_points[pick];
                    stored_points.delete(pick);
                end
                add_req(REQ_REMOVE, c[0], c[1], c[2]);
            end
            else
            begin
                for (int ax = 0; ax < 3; ax++)
                    raw[ax] = COORD_W'($urandom);
                add_req(REQ_W'($urandom_range(0, 3)), int'(raw[0]), int'(raw[1]),
                        int'(raw[2]));
            end
        end
        drain();
    endtask

    initial
    begin
        m_recip = int'(RECIP_RESET);
        m_maxp = int'(MAXP_RESET);
        m_maxd = longint'(MAXD_RESET);
        for (int i = 0; i < VOXEL_SLOTS; i++)
        begin
            m_valid[i] = 1'b0;
            m_cnt[i] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: eviction, ties, threshold, removes, extremes, unused request
        send_idle = 26;
        recv_idle = 84;
        write_reg(CFG_MAXP, CFG_W'(2));
        add_req(REQ_INSERT, 0, 0, 0);
        add_req(REQ_INSERT, 1, 1, 1);
        add_req(REQ_INSERT, 2, 2, 2);
        add_req(REQ_QUERY, 3, 3, 3);
        add_req(REQ_QUERY, 2000, 2000, 2000);
        add_req(REQ_REMOVE, 7, 7, 7);
        add_req(REQ_REMOVE, 5000, 0, 0);
        add_req(REQ_REMOVE, 1, 1, 1);
        add_req(REQ_REMOVE, 2, 2, 2);
        add_req(REQ_QUERY, 0, 0, 0);
        add_req(REQ_INSERT, 100, 0, 0);
        add_req(REQ_INSERT, -100, 0, 0);
        add_req(REQ_QUERY, 0, 0, 0);
        add_req(REQ_INSERT, 300, 0, 0);
        add_req(REQ_QUERY, 250, 0, 0);
        add_req(REQ_QUERY, 0, 600, 0);
        add_req(REQ_INSERT, 8388607, 8388607, 8388607);
        add_req(REQ_INSERT, -8388608, -8388608, -8388608);
        add_req(REQ_QUERY, 8388607, 8388600, 8388607);
        add_req(REQ_QUERY, -8388608, -8388608, -8388400);
        add_req(REQ_REMOVE, -8388608, -8388608, -8388608);
        add_req(REQ_QUERY, -8388608, -8388608, -8388608);
        add_req(REQ_UNUSED, -1, -1, -1);
        add_req(REQ_QUERY, -1, -1, -1);
        drain();
        write_reg(CFG_MAXD, CFG_W'(10000));
        add_req(REQ_QUERY, 0, 0, 0);
        drain();

        write_reg(CFG_RECIP, CFG_W'(RECIP_RESET));
        write_reg(CFG_MAXP, CFG_W'(MAXP_RESET));
        write_reg(CFG_MAXD, CFG_W'(MAXD_RESET));
        random_phase(104);
        write_reg(CFG_RECIP, CFG_W'(16'hFFFF));
        write_reg(CFG_MAXP, CFG_W'(1));
        write_reg(CFG_MAXD, {DIST_W{1'b1}});
        random_phase(104);

        send_idle = 84;
        recv_idle = 26;
        write_reg(CFG_RECIP, CFG_W'(1));
        write_reg(CFG_MAXP, CFG_W'(3));
        write_reg(CFG_MAXD, CFG_W'(0));
        random_phase(104);
        write_reg(CFG_RECIP, CFG_W'(300));
        write_reg(CFG_MAXP, CFG_W'(0));
        write_reg(CFG_MAXD, CFG_W'(1000000));
        random_phase(104);

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_RECIP, CFG_W'(16384));
        write_reg(CFG_MAXP, CFG_W'(15));
        write_reg(CFG_MAXD, CFG_W'(4000));
        write_reg(CFG_UNUSED, {CFG_W{1'b1}});
        random_phase(104);
        write_reg(CFG_RECIP, CFG_W'(RECIP_RESET));
        write_reg(CFG_MAXP, CFG_W'(MAXP_RESET));
        write_reg(CFG_MAXD, CFG_W'(MAXD_RESET));
        random_phase(104);

        repeat (50) @(posedge clk);
        $display("run covered %0d requests over seven register settings and three idling mixes",
                 taken_cnt);
        $display("status counts from stored to no match: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
